>>> sv/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared types, widths and codes for the envelope controller and datapath.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int SAMPLE_TIME_W = 32;
  localparam int DUR_W         = 24;
  localparam int SUS_W         = 17;
  localparam int PHASE_W       = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

  localparam logic [SUS_W-1:0] SUSTAIN_RESET = 17'h10000;

  typedef enum logic [PHASE_W-1:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_IDLE    = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADJUST,
    ST_ELAPSE,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_APPLY,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic adjust;
    logic elapse;
    logic settle;
    logic div_init;
    logic div_step;
    logic mul1;
    logic mul2;
    logic apply;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic is_attack;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// ADSR envelope controller
// Sequences one sample through phase update, division, squaring and output.
// ----------------------------------------------------------------------------
module adsr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  adsr_pkg::dp_status_t status_i,
  output adsr_pkg::dp_cmd_t   cmd_o
);

  adsr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      adsr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = adsr_pkg::ST_ADJUST;
        end
      end
      adsr_pkg::ST_ADJUST: begin
        cmd_o.adjust = 1'b1;
        state_d      = adsr_pkg::ST_ELAPSE;
      end
      adsr_pkg::ST_ELAPSE: begin
        cmd_o.elapse = 1'b1;
        state_d      = adsr_pkg::ST_CHECK;
      end
      adsr_pkg::ST_CHECK: begin
        if (status_i.need_div) begin
          state_d = adsr_pkg::ST_DIV_INIT;
        end else begin
          cmd_o.settle = 1'b1;
          state_d      = adsr_pkg::ST_EMIT;
        end
      end
      adsr_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = adsr_pkg::ST_DIV;
      end
      adsr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = adsr_pkg::ST_MUL1;
        end
      end
      adsr_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = status_i.is_attack ? adsr_pkg::ST_APPLY : adsr_pkg::ST_MUL2;
      end
      adsr_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = adsr_pkg::ST_APPLY;
      end
      adsr_pkg::ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = adsr_pkg::ST_EMIT;
      end
      adsr_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = adsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = adsr_pkg::ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("More than one datapath command in one cycle.");

  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adsr_pkg::ST_DIV && status_i.div_last) |=> state_q == adsr_pkg::ST_MUL1)
    else $error("Division did not hand over to the multiplier.");

  a_settle_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adsr_pkg::ST_CHECK && !status_i.need_div) |=> state_q == adsr_pkg::ST_EMIT)
    else $error("A settled sample did not go to the output.");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adsr_pkg::ST_EMIT && status_i.out_free) |=> state_q == adsr_pkg::ST_IDLE)
    else $error("Controller did not return to idle after the output transfer.");

endmodule

>>> sv/adsr_datapath.sv
// ----------------------------------------------------------------------------
// ADSR envelope datapath
// Envelope state, configuration registers, divider, multiplier and output.
// ----------------------------------------------------------------------------
module adsr_datapath #(
  parameter int TIME_BITS       = 32,
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [adsr_pkg::SAMPLE_TIME_W-1:0]  sample_time_i,
  input  logic                                first_sample_i,
  input  logic                                key_released_i,
  input  adsr_pkg::dp_cmd_t                   cmd_i,
  output adsr_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [LEVEL_FRAC_BITS:0]            level_o,
  output logic [adsr_pkg::PHASE_W-1:0]        phase_now_o
);

  localparam int LW    = LEVEL_FRAC_BITS + 1;
  localparam int PW    = 2 * LW;
  localparam int DW    = (TIME_BITS > adsr_pkg::SAMPLE_TIME_W) ? TIME_BITS
                                                               : adsr_pkg::SAMPLE_TIME_W;
  localparam int CW    = (TIME_BITS > adsr_pkg::DUR_W) ? TIME_BITS : adsr_pkg::DUR_W;
  localparam int SW    = (LW > adsr_pkg::SUS_W) ? LW : adsr_pkg::SUS_W;
  localparam int RW    = adsr_pkg::DUR_W + 1;
  localparam int CNT_W = $clog2(LW);
  localparam logic [LW-1:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  logic [adsr_pkg::DUR_W-1:0]         attack_q, attack_d, decay_q, decay_d;
  logic [adsr_pkg::DUR_W-1:0]         release_q, release_d;
  logic [adsr_pkg::SUS_W-1:0]         sustain_q, sustain_d;
  adsr_pkg::phase_e                   phase_q, phase_d;
  logic [adsr_pkg::SAMPLE_TIME_W-1:0] start_q, start_d;
  logic [LW-1:0]                      held_q, held_d, last_q, last_d;

  logic [adsr_pkg::SAMPLE_TIME_W-1:0] now_q, now_d;
  logic                               first_q, first_d, rel_q, rel_d;
  logic [CW-1:0]                      el_q, el_d;
  logic [adsr_pkg::DUR_W-1:0]         dur_q, dur_d;
  logic [RW-1:0]                      rem_q, rem_d;
  logic [LW-1:0]                      quo_q, quo_d;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;
  logic [PW-1:0]                      prod_q, prod_d;

  logic                               out_valid_q, out_valid_d;
  logic [LW-1:0]                      out_level_q, out_level_d;
  logic [adsr_pkg::PHASE_W-1:0]       out_phase_q, out_phase_d;

  adsr_pkg::phase_e                   ph_mid;
  logic [adsr_pkg::SAMPLE_TIME_W-1:0] start_mid;
  logic [DW-1:0]                      diff;
  logic [adsr_pkg::DUR_W-1:0]         dur_sel;
  logic                               ends;
  logic [SW-1:0]                      sus_ext;
  logic [LW-1:0]                      sus_sat;
  logic                               rem_ge;
  logic [RW-1:0]                      rem_sub;
  logic [LW-1:0]                      sq;
  logic [LW-1:0]                      mul_a, mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q    <= '0;
      decay_q     <= '0;
      sustain_q   <= adsr_pkg::SUSTAIN_RESET;
      release_q   <= '0;
      phase_q     <= adsr_pkg::PH_IDLE;
      start_q     <= '0;
      held_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      attack_q    <= attack_d;
      decay_q     <= decay_d;
      sustain_q   <= sustain_d;
      release_q   <= release_d;
      phase_q     <= phase_d;
      start_q     <= start_d;
      held_q      <= held_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    first_q     <= first_d;
    rel_q       <= rel_d;
    el_q        <= el_d;
    dur_q       <= dur_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    prod_q      <= prod_d;
    out_level_q <= out_level_d;
    out_phase_q <= out_phase_d;
  end

  always_comb begin
    attack_d  = attack_q;
    decay_d   = decay_q;
    sustain_d = sustain_q;
    release_d = release_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        adsr_pkg::CFG_ATTACK:  attack_d  = cfg_data_i[adsr_pkg::DUR_W-1:0];
        adsr_pkg::CFG_DECAY:   decay_d   = cfg_data_i[adsr_pkg::DUR_W-1:0];
        adsr_pkg::CFG_SUSTAIN: sustain_d = cfg_data_i[adsr_pkg::SUS_W-1:0];
        adsr_pkg::CFG_RELEASE: release_d = cfg_data_i[adsr_pkg::DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ph_mid    = phase_q;
    start_mid = start_q;
    if (first_q) begin
      ph_mid    = adsr_pkg::PH_ATTACK;
      start_mid = '0;
    end
    if (rel_q && ph_mid != adsr_pkg::PH_RELEASE && ph_mid != adsr_pkg::PH_IDLE) begin
      ph_mid    = adsr_pkg::PH_RELEASE;
      start_mid = now_q;
    end
  end

  always_comb begin
    case (phase_q)
      adsr_pkg::PH_ATTACK:  dur_sel = attack_q;
      adsr_pkg::PH_DECAY:   dur_sel = decay_q;
      adsr_pkg::PH_RELEASE: dur_sel = release_q;
      default:              dur_sel = '0;
    endcase
  end

  assign diff    = DW'(now_q) - DW'(start_q);
  assign ends    = (dur_q == '0) || (el_q > CW'(dur_q));
  assign sus_ext = SW'(sustain_q);
  assign sus_sat = (sus_ext > SW'(ONE)) ? ONE : sus_ext[LW-1:0];
  assign rem_ge  = rem_q >= RW'(dur_q);
  assign rem_sub = rem_ge ? (rem_q - RW'(dur_q)) : rem_q;
  assign sq      = prod_q[2*LEVEL_FRAC_BITS:LEVEL_FRAC_BITS];

  always_comb begin
    if (cmd_i.mul1) begin
      mul_a = (phase_q == adsr_pkg::PH_DECAY) ? quo_q : (ONE - quo_q);
      mul_b = mul_a;
    end else begin
      mul_a = (phase_q == adsr_pkg::PH_RELEASE) ? held_q : (ONE - sus_sat);
      mul_b = sq;
    end
  end

  always_comb begin
    now_d   = now_q;
    first_d = first_q;
    rel_d   = rel_q;
    el_d    = el_q;
    dur_d   = dur_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    phase_d = phase_q;
    start_d = start_q;
    held_d  = held_q;
    last_d  = last_q;
    if (cmd_i.load_in) begin
      now_d   = sample_time_i;
      first_d = first_sample_i;
      rel_d   = key_released_i;
    end
    if (cmd_i.adjust) begin
      phase_d = ph_mid;
      start_d = start_mid;
    end
    if (cmd_i.elapse) begin
      el_d  = CW'(diff[TIME_BITS-1:0]);
      dur_d = dur_sel;
    end
    if (cmd_i.settle) begin
      case (phase_q)
        adsr_pkg::PH_ATTACK: begin
          phase_d = adsr_pkg::PH_DECAY;
          start_d = now_q;
          held_d  = ONE;
          last_d  = ONE;
        end
        adsr_pkg::PH_DECAY: begin
          phase_d = adsr_pkg::PH_SUSTAIN;
          start_d = now_q;
          held_d  = sus_sat;
          last_d  = sus_sat;
        end
        adsr_pkg::PH_SUSTAIN: begin
          held_d = sus_sat;
          last_d = sus_sat;
        end
        default: begin
          phase_d = adsr_pkg::PH_IDLE;
        end
      endcase
    end
    if (cmd_i.div_init) begin
      rem_d = RW'(el_q[adsr_pkg::DUR_W-1:0]);
      quo_d = '0;
      cnt_d = CNT_W'(LEVEL_FRAC_BITS);
    end
    if (cmd_i.div_step) begin
      rem_d = {rem_sub[RW-2:0], 1'b0};
      quo_d = {quo_q[LW-2:0], rem_ge};
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.mul1 || cmd_i.mul2) begin
      prod_d = PW'(mul_a) * PW'(mul_b);
    end
    if (cmd_i.apply) begin
      if (phase_q == adsr_pkg::PH_RELEASE) begin
        last_d = sq;
      end else begin
        held_d = ONE - sq;
        last_d = ONE - sq;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_level_d = out_level_q;
    out_phase_d = out_phase_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_level_d = last_q;
      out_phase_d = phase_q;
    end
  end

  assign status_o.need_div  = (phase_q == adsr_pkg::PH_ATTACK || phase_q == adsr_pkg::PH_DECAY
                               || phase_q == adsr_pkg::PH_RELEASE) && !ends;
  assign status_o.div_last  = (cnt_q == '0);
  assign status_o.is_attack = (phase_q == adsr_pkg::PH_ATTACK);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign phase_now_o = out_phase_q;

endmodule

>>> sv/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator
// One envelope level per audio sample, attack, decay, sustain and release.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one sample per transfer (sample_time_i,
// first_sample_i, key_released_i) under in_valid_i and in_stall_o. Each
// sample gives exactly one result (level_o, phase_now_o) on the output
// channel under out_valid_o and out_stall_i. The configuration channel
// (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) writes attack, decay,
// sustain and release at indexes 0 to 3; it is always ready and should be
// used only while no sample is in flight.
// One sample is worked on at a time. A sample that ends or holds its phase
// goes from the input transfer through the adjust, elapse, check and emit
// states to its result, and the next sample can be taken once the controller
// is back in idle. A sample that computes a ratio runs the one-bit-per-cycle
// divider over the whole quotient and then the shared multiplier twice before
// the apply and emit states. Attack uses the multiplier only once.
// The output register lets the next sample be taken while a result waits.
// When the receiver stalls, the result holds and the controller waits
// before loading the following result. Reset clears the envelope to idle
// with level zero and loads the register defaults.
// ----------------------------------------------------------------------------
module adsr_envelope_generator #(
  parameter int TIME_BITS       = 32,
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [adsr_pkg::SAMPLE_TIME_W-1:0]  sample_time_i,
  input  logic                                first_sample_i,
  input  logic                                key_released_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [LEVEL_FRAC_BITS:0]            level_o,
  output logic [adsr_pkg::PHASE_W-1:0]        phase_now_o
);

  adsr_pkg::dp_cmd_t    cmd;
  adsr_pkg::dp_status_t status;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  adsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adsr_datapath #(
    .TIME_BITS       (TIME_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_time_i  (sample_time_i),
    .first_sample_i (first_sample_i),
    .key_released_i (key_released_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_o        (level_o),
    .phase_now_o    (phase_now_o)
  );

endmodule
